>>> hdl/tllc_pkg.sv
// Package: geometry constants, config register indexes and shared types for the two-level cache.
package tllc_pkg;

  localparam int unsigned L1Ways    = 4;
  localparam int unsigned L1SetBits = 6;
  localparam int unsigned L2Ways    = 4;
  localparam int unsigned L2SetBits = 12;
  localparam int unsigned L1WayW    = (L1Ways > 1) ? $clog2(L1Ways) : 1;
  localparam int unsigned L2WayW    = 2;
  localparam int unsigned L1AddrW   = (L1SetBits > 0) ? L1SetBits : 1;
  localparam int unsigned L2AddrW   = (L2SetBits > 0) ? L2SetBits : 1;
  localparam int unsigned L1Sets    = 1 << L1SetBits;
  localparam int unsigned L2Sets    = 1 << L2SetBits;

  typedef enum logic [2:0] {
    RegL1Offset = 3'd0,
    RegL1Index  = 3'd1,
    RegL1Ways   = 3'd2,
    RegL2Offset = 3'd3,
    RegL2Index  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OutL1Hit  = 2'd0,
    OutL2Hit  = 2'd1,
    OutMiss   = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    StIdle,
    StL1Read,
    StL2Read,
    StWrite,
    StOut,
    StClear
  } state_e;

  // one way of a tag store row
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] stamp;
  } way_t;

  typedef way_t [L1Ways-1:0] l1_row_t;
  typedef way_t [L2Ways-1:0] l2_row_t;

  typedef struct packed {
    logic [3:0] l1_offset;
    logic [2:0] l1_index;
    logic [2:0] l1_ways;
    logic [3:0] l2_offset;
    logic [3:0] l2_sbits;
  } cfg_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

>>> hdl/two_level_lru_cache_model_unit.sv
// Top level: two-level LRU tag-store model with stream ports and config port.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-------------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready | tdata[31:0] address
//  m_axis    | out       | m_axis_tvalid/tready | tdata[1:0] outcome, [33:2] access_total,
//            |           |                      | [65:34] l1_hit, [97:66] l2_hit, [129:98] miss
//  cfg       | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An L1 hit passes through accept with L1 row read, lookup and write-back, and result
// register load; an L1 miss passes through accept, L1 lookup, L2 lookup and write-back,
// L1 fill, and result register load. The synchronous memory reads set these steps;
// a stalled result holds the unit in its last step.
// After reset an L2 clearing pass over all 4096 rows (one row per cycle) runs before
// the first item is taken; config writes are taken throughout.
module two_level_lru_cache_model_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] address
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // outcome, access, l1 hit, l2 hit, miss totals
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [7:0]   cfg_data
);
  import tllc_pkg::*;

  state_e state_q, state_d;
  cfg_t   cfg_q;
  logic [31:0] addr_q;
  logic [31:0] addr_cur;
  logic [31:0] acc_q, l1h_q, l2h_q, miss_q;
  logic [31:0] acc_d, l1h_d, l2h_d, miss_d;
  logic [1:0]  outc_q;
  logic [L2AddrW-1:0] clr_q;
  logic [L1WayW-1:0] l1_way_q;
  l1_row_t     l1_row_q;
  l1_row_t     l1_rd, l1_wd;
  l2_row_t     l2_rd, l2_wd;
  logic        l1_we, l2_we;
  logic [L2AddrW-1:0] l2_waddr;
  logic [135:0] out_q;
  logic        out_vld_q;
  logic        out_load;

  // geometry
  logic [2:0]  i1b, ways;
  logic [3:0]  i2b;
  logic [31:0] sh1, sh2, tag1, tag2;
  logic [L1AddrW-1:0] set1;
  logic [L2AddrW-1:0] set2;
  logic [4:0]  t1s, t2s;

  // the incoming address drives the row reads on the accepting edge
  assign addr_cur = (state_q == StIdle) ? s_axis_tdata : addr_q;

  always_comb begin
    i1b  = (cfg_q.l1_index > 3'(L1SetBits)) ? 3'(L1SetBits) : cfg_q.l1_index;
    i2b  = (cfg_q.l2_sbits > 4'(L2SetBits)) ? 4'(L2SetBits) : cfg_q.l2_sbits;
    ways = (cfg_q.l1_ways == 3'd0) ? 3'd1 :
           ((cfg_q.l1_ways > 3'(L1Ways)) ? 3'(L1Ways) : cfg_q.l1_ways);
    sh1  = addr_cur >> cfg_q.l1_offset;
    sh2  = addr_cur >> cfg_q.l2_offset;
    set1 = L1AddrW'(sh1 & ((32'd1 << i1b) - 32'd1));
    set2 = L2AddrW'(sh2 & ((32'd1 << i2b) - 32'd1));
    t1s  = 5'(cfg_q.l1_offset) + 5'(i1b);
    t2s  = 5'(cfg_q.l2_offset) + 5'(i2b);
    tag1 = addr_cur >> t1s;
    tag2 = addr_cur >> t2s;
  end

  tllc_l1_mem u_l1 (
    .clk_i, .rst_ni, .raddr_i(set1), .rdata_o(l1_rd),
    .we_i(l1_we), .waddr_i(set1), .wdata_i(l1_wd)
  );

  tllc_l2_mem u_l2 (
    .clk_i, .raddr_i(set2), .rdata_o(l2_rd),
    .we_i(l2_we), .waddr_i(l2_waddr), .wdata_i(l2_wd)
  );

  // L1 lookup on row read in StL1Read
  logic              l1_hit;
  logic [L1WayW-1:0] l1_hw, l1_vw;
  logic              l1_found_inv;
  always_comb begin
    l1_hit = 1'b0; l1_hw = '0; l1_found_inv = 1'b0; l1_vw = '0;
    for (int w = L1Ways - 1; w >= 0; w--) begin
      if (w < ways && l1_rd[w].valid && l1_rd[w].tag == tag1) begin
        l1_hit = 1'b1; l1_hw = L1WayW'(w);
      end
    end
    for (int w = L1Ways - 1; w >= 0; w--) begin
      if (w < ways && !l1_rd[w].valid) begin
        l1_found_inv = 1'b1; l1_vw = L1WayW'(w);
      end
    end
    if (!l1_found_inv) begin
      for (int w = 1; w < L1Ways; w++) begin
        if (w < ways && l1_rd[w].stamp < l1_rd[l1_vw].stamp) l1_vw = L1WayW'(w);
      end
    end
  end

  // L2 lookup on row read in StL2Read
  logic              l2_hit, l2_found_inv;
  logic [L2WayW-1:0] l2_hw, l2_vw;
  always_comb begin
    l2_hit = 1'b0; l2_hw = '0; l2_found_inv = 1'b0; l2_vw = '0;
    for (int w = L2Ways - 1; w >= 0; w--) begin
      if (l2_rd[w].valid && l2_rd[w].tag == tag2) begin
        l2_hit = 1'b1; l2_hw = L2WayW'(w);
      end
      if (!l2_rd[w].valid) begin
        l2_found_inv = 1'b1; l2_vw = L2WayW'(w);
      end
    end
    if (!l2_found_inv) begin
      for (int w = 1; w < L2Ways; w++) begin
        if (l2_rd[w].stamp < l2_rd[l2_vw].stamp) l2_vw = L2WayW'(w);
      end
    end
  end

  // result register loads once it is free or being drained
  assign out_load = (state_q == StOut) && (!out_vld_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:  if (clr_q == L2AddrW'(L2Sets - 1)) state_d = StIdle;
      StIdle:   if (s_axis_tvalid) state_d = StL1Read;
      StL1Read: state_d = l1_hit ? StOut : StL2Read;
      StL2Read: state_d = StWrite;
      StWrite:  state_d = StOut;
      StOut:    if (!out_vld_q || m_axis_tready) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // outputs and memory write control
  always_comb begin
    l1_we = 1'b0; l2_we = 1'b0;
    l1_wd = l1_row_q; l2_wd = l2_rd;
    l2_waddr = set2;
    acc_d = acc_q; l1h_d = l1h_q; l2h_d = l2h_q; miss_d = miss_q;
    unique case (state_q)
      StClear: begin
        l2_we = 1'b1; l2_waddr = clr_q;
        for (int w = 0; w < L2Ways; w++) l2_wd[w] = '0;
      end
      StL1Read: begin
        acc_d = sat_inc(acc_q);
        if (l1_hit) begin
          l1_we = 1'b1;
          l1_wd = l1_rd;
          l1_wd[l1_hw].stamp = sat_inc(acc_q);
          l1h_d = sat_inc(l1h_q);
        end
      end
      StL2Read: begin
        l2_we = 1'b1;
        if (l2_hit) begin
          l2_wd[l2_hw].stamp = acc_q;
          l2h_d = sat_inc(l2h_q);
        end else begin
          l2_wd[l2_vw] = '{valid: 1'b1, tag: tag2, stamp: acc_q};
          miss_d = sat_inc(miss_q);
        end
      end
      StWrite: begin
        l1_we = 1'b1;
        l1_wd[l1_way_q] = '{valid: 1'b1, tag: tag1, stamp: acc_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      cfg_q     <= '{l1_offset: 4'd2, l1_index: 3'd6, l1_ways: 3'd4,
                     l2_offset: 4'd4, l2_sbits: 4'd6};
      acc_q <= '0; l1h_q <= '0; l2h_q <= '0; miss_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q <= acc_d; l1h_q <= l1h_d; l2h_q <= l2h_d; miss_q <= miss_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (cfg_valid) begin
        unique case (cfg_index)
          RegL1Offset: cfg_q.l1_offset <= cfg_data[3:0];
          RegL1Index:  cfg_q.l1_index  <= cfg_data[2:0];
          RegL1Ways:   cfg_q.l1_ways   <= cfg_data[2:0];
          RegL2Offset: cfg_q.l2_offset <= cfg_data[3:0];
          RegL2Index:  cfg_q.l2_sbits  <= cfg_data[3:0];
          default: ;
        endcase
      end
      out_vld_q <= out_load | (out_vld_q & ~m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) addr_q <= s_axis_tdata;
    if (state_q == StL1Read) begin
      l1_way_q <= l1_vw;
      l1_row_q <= l1_rd;
      outc_q   <= OutL1Hit;
    end
    if (state_q == StL2Read) outc_q <= l2_hit ? OutL2Hit : OutMiss;
    if (out_load) begin
      out_q <= {6'd0, miss_q, l2h_q, l1h_q, acc_q, outc_q};
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
endmodule

>>> hdl/tllc_l1_mem.sv
// L1 tag store: one row per set, synchronous read, with per-set valid flags.
module tllc_l1_mem (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tllc_pkg::L1AddrW-1:0] raddr_i,
  output tllc_pkg::l1_row_t        rdata_o,
  input  logic                     we_i,
  input  logic [tllc_pkg::L1AddrW-1:0] waddr_i,
  input  tllc_pkg::l1_row_t        wdata_i
);
  import tllc_pkg::*;

  l1_row_t                 mem_q [L1Sets];
  logic [L1Sets-1:0]       seen_q;
  l1_row_t                 rd_q;
  logic                    rd_seen_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rd_q <= mem_q[raddr_i];
  end

  // rows never written read as all ways invalid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      rd_seen_q <= 1'b0;
    end else begin
      if (we_i) seen_q[waddr_i] <= 1'b1;
      rd_seen_q <= seen_q[raddr_i];
    end
  end

  always_comb begin
    rdata_o = rd_q;
    for (int w = 0; w < L1Ways; w++) begin
      rdata_o[w].valid = rd_q[w].valid & rd_seen_q;
    end
  end
endmodule

>>> hdl/tllc_l2_mem.sv
// L2 tag store: one row per set, synchronous read; valid bits cleared by a sweep.
module tllc_l2_mem (
  input  logic                     clk_i,
  input  logic [tllc_pkg::L2AddrW-1:0] raddr_i,
  output tllc_pkg::l2_row_t        rdata_o,
  input  logic                     we_i,
  input  logic [tllc_pkg::L2AddrW-1:0] waddr_i,
  input  tllc_pkg::l2_row_t        wdata_i
);
  import tllc_pkg::*;

  l2_row_t mem_q [L2Sets];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> test/two_level_lru_cache_model_unit_test.sv
// Testbench: two-level LRU cache tag model, self-checking against its own predictor.
`timescale 1ns / 1ps

module two_level_lru_cache_model_unit_test;
  import tllc_pkg::*;

  // Writes to this index land on no register and must be dropped.
  localparam logic [2:0] RegUnused = 3'd6;
  // Idle cycles allowed before the run is declared hung. This covers the
  // L2 clearing pass after reset.
  localparam int unsigned WatchLimit = 20000;
  // Drain time after the last result.
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned L1Depth = L1Sets * L1Ways;
  localparam int unsigned L2Depth = L2Sets * L2Ways;

  typedef struct {
    outcome_e    outcome;
    logic [31:0] access_total;
    logic [31:0] l1_hits;
    logic [31:0] l2_hits;
    logic [31:0] misses;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;

  two_level_lru_cache_model_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk_i = ~clk_i;

  // Geometry as the unit should see it.
  logic [3:0] geo_l1_offset = 4'd2;
  logic [2:0] geo_l1_index  = 3'd6;
  logic [2:0] geo_l1_ways   = 3'd4;
  logic [3:0] geo_l2_offset = 4'd4;
  logic [3:0] geo_l2_index  = 4'd6;

  // Shadow tag stores and counters.
  logic        l1_v [L1Depth];
  logic [31:0] l1_t [L1Depth];
  logic [31:0] l1_s [L1Depth];
  logic        l2_v [L2Depth];
  logic [31:0] l2_t [L2Depth];
  logic [31:0] l2_s [L2Depth];
  logic [31:0] n_access = '0, n_l1_hit = '0, n_l2_hit = '0, n_miss = '0;

  logic [31:0] addr_queue [$];   // addresses waiting to be sent
  lookup_t     lookup_queue [$]; // expected results, oldest first
  int unsigned mismatches = 0;

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // Picks first invalid way, else lowest stamp (ties to lowest way).
  function automatic int unsigned l1_victim(input int unsigned base, input int unsigned n);
    int unsigned best;
    best = 0;
    for (int unsigned i = 0; i < n; i++) if (!l1_v[base + i]) return i;
    for (int unsigned i = 1; i < n; i++) if (l1_s[base + i] < l1_s[base + best]) best = i;
    return best;
  endfunction

  function automatic int unsigned l2_victim(input int unsigned base);
    int unsigned best;
    best = 0;
    for (int unsigned i = 0; i < L2Ways; i++) if (!l2_v[base + i]) return i;
    for (int unsigned i = 1; i < L2Ways; i++) if (l2_s[base + i] < l2_s[base + best]) best = i;
    return best;
  endfunction

  // Runs one access through the shadow stores and returns what the unit must report.
  function automatic lookup_t cache_access(input logic [31:0] addr);
    int unsigned ways, i1b, i2b, base1, base2, w;
    logic [31:0] tag1, tag2, now;
    bit found;
    lookup_t r;
    ways = (geo_l1_ways == 0) ? 1 : (geo_l1_ways > L1Ways) ? L1Ways : geo_l1_ways;
    i1b = (geo_l1_index > L1SetBits) ? L1SetBits : geo_l1_index;
    i2b = (geo_l2_index > L2SetBits) ? L2SetBits : geo_l2_index;
    base1 = ((addr >> geo_l1_offset) & ((32'd1 << i1b) - 1)) * L1Ways;
    base2 = ((addr >> geo_l2_offset) & ((32'd1 << i2b) - 1)) * L2Ways;
    tag1 = addr >> (geo_l1_offset + i1b);
    tag2 = addr >> (geo_l2_offset + i2b);
    n_access = bump(n_access);
    now = n_access;
    found = 0;
    for (w = 0; w < ways; w++) if (l1_v[base1 + w] && l1_t[base1 + w] == tag1) begin
      found = 1;
      break;
    end
    if (found) begin
      l1_s[base1 + w] = now;
      n_l1_hit = bump(n_l1_hit);
      r.outcome = OutL1Hit;
    end else begin
      for (w = 0; w < L2Ways; w++) if (l2_v[base2 + w] && l2_t[base2 + w] == tag2) begin
        found = 1;
        break;
      end
      if (found) begin
        l2_s[base2 + w] = now;
        n_l2_hit = bump(n_l2_hit);
        r.outcome = OutL2Hit;
      end else begin
        w = l2_victim(base2);
        l2_v[base2 + w] = 1'b1;
        l2_t[base2 + w] = tag2;
        l2_s[base2 + w] = now;
        n_miss = bump(n_miss);
        r.outcome = OutMiss;
      end
      // L1 fills its own victim in both miss cases
      w = l1_victim(base1, ways);
      l1_v[base1 + w] = 1'b1;
      l1_t[base1 + w] = tag1;
      l1_s[base1 + w] = now;
    end
    r.access_total = n_access;
    r.l1_hits = n_l1_hit;
    r.l2_hits = n_l2_hit;
    r.misses = n_miss;
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) lookup_queue.push_back(cache_access(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (addr_queue.size() > 0) begin
          s_axis_tdata <= addr_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            // end of burst: some bursts are followed by no gap at all
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls on a rotating pattern; each reshuffle makes it all-ready, mostly stalled or random.
  logic [15:0] stall_pattern = 16'hFFFF;
  int unsigned rx_cycle = 0;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 63) begin
      case ($urandom_range(0, 3))
        0: stall_pattern <= 16'hFFFF;
        1: stall_pattern <= 16'h0001;
        default: stall_pattern <= 16'($urandom) | 16'h0001;
      endcase
    end else begin
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
    end
    m_axis_tready <= stall_pattern[15];
  end

  // Result checker.
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (lookup_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = lookup_queue.pop_front();
        if (m_axis_tdata[1:0] !== want.outcome || m_axis_tdata[33:2] !== want.access_total ||
            m_axis_tdata[65:34] !== want.l1_hits || m_axis_tdata[97:66] !== want.l2_hits ||
            m_axis_tdata[129:98] !== want.misses) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected outcome %0d totals %0d/%0d/%0d/%0d, got %0d %0d/%0d/%0d/%0d",
                     want.outcome, want.access_total, want.l1_hits, want.l2_hits, want.misses,
                     m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[65:34],
                     m_axis_tdata[97:66], m_axis_tdata[129:98]);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("two_level_lru_cache_model_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes the full geometry plus one write to an unused index, back to back.
  task automatic set_geometry(input logic [7:0] l1o, l1i, l1w, l2o, l2i);
    logic [2:0] idx [6];
    logic [7:0] val [6];
    idx = '{RegL1Offset, RegL1Index, RegL1Ways, RegL2Offset, RegL2Index, RegUnused};
    val = '{l1o, l1i, l1w, l2o, l2i, 8'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready);
      case (idx[i])
        RegL1Offset: geo_l1_offset = val[i][3:0];
        RegL1Index:  geo_l1_index  = val[i][2:0];
        RegL1Ways:   geo_l1_ways   = val[i][2:0];
        RegL2Offset: geo_l2_offset = val[i][3:0];
        RegL2Index:  geo_l2_index  = val[i][3:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait for everything in flight to drain, then a few more cycles.
  task automatic wait_idle();
    while (addr_queue.size() > 0 || s_axis_tvalid || lookup_queue.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly reuse a small working set so hits, evictions and refills happen.
  task automatic queue_traffic(input int unsigned count);
    logic [31:0] pool [16];
    logic [31:0] a;
    foreach (pool[i]) pool[i] = $urandom;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(0, 7))
        0, 1: a = $urandom;
        2: a = pool[$urandom_range(0, 15)] ^ ($urandom_range(0, 255) << $urandom_range(0, 20));
        default: a = pool[$urandom_range(0, 15)] ^ $urandom_range(0, 15);
      endcase
      addr_queue.push_back(a);
    end
  endtask

  initial begin
    foreach (l1_v[i]) l1_v[i] = 1'b0;
    foreach (l2_v[i]) l2_v[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry, written explicitly.
    set_geometry(2, 6, 4, 4, 6);
    // Directed: extremes, a repeat hit, then five tags into one L1 set so the
    // first block falls out of L1 but is still found in L2.
    addr_queue = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1,
                   32'h100, 32'h200, 32'h300, 32'h400, 32'h500, 32'h0,
                   32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5554, 32'h8000_0000};
    wait_idle();

    // One set, one way: every new block evicts.
    set_geometry(0, 0, 1, 0, 0);
    addr_queue = '{32'h0, 32'h0, 32'h1, 32'h0, 32'h2, 32'h3, 32'h4, 32'h1, 32'h0};
    queue_traffic(110);
    wait_idle();

    // Out-of-range values: ways clamp, index bits clamp, big offsets.
    set_geometry(15, 7, 7, 15, 15);
    queue_traffic(115);
    wait_idle();

    // Zero ways is treated as one.
    set_geometry(8, 6, 0, 8, 12);
    queue_traffic(115);
    wait_idle();

    set_geometry(3, 2, 2, 5, 13);
    queue_traffic(115);
    wait_idle();

    // Geometry changes with the stores kept; random settings.
    repeat (4) begin
      set_geometry(8'($urandom_range(0, 15)), 8'($urandom_range(0, 7)),
                   8'($urandom_range(0, 7)), 8'($urandom_range(0, 15)),
                   8'($urandom_range(0, 15)));
      queue_traffic(115);
      wait_idle();
    end

    if (mismatches == 0 && lookup_queue.size() == 0) begin
      $display("two_level_lru_cache_model_unit test passed");
    end else begin
      $display("two_level_lru_cache_model_unit test failed");
    end
    $finish;
  end

endmodule
